>>> design/kwta_pkg.sv
// Shared types and constants for the k-winners-take-all selector.
package kwta_pkg;

   localparam int ACT_W = 32;
   localparam int OUT_IDX_W = 10;
   localparam int TAG_W = 16;
   localparam int K_W = 7;
   localparam logic [K_W-1:0] K_RESET = 7'd8;

   typedef struct packed {
      logic [ACT_W-1:0] activation;
      logic             last_item;
   } req_beat_type;

   typedef struct packed {
      logic [OUT_IDX_W-1:0] winner_index;
      logic                 last_winner;
   } rsp_beat_type;

   // Classified beat that travels from the front to the back.
   typedef struct packed {
      logic [ACT_W-1:0] activation;
      logic [TAG_W-1:0] index;
      logic             last_item;
      logic             keep;
   } tag_beat_type;

   typedef enum logic [1:0] {
      BACK_INSERT,
      BACK_SORT,
      BACK_EMIT
   } back_state_type;

endpackage

>>> design/kwta_front.sv
// Front end: accepts beats, numbers them within the run and flags overflow.
module kwta_front import kwta_pkg::*; #(
   parameter int MAX_NEURONS = 1024
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_beat_type req_data,
   output logic         push,
   output tag_beat_type push_data,
   input  logic         queue_full
);
   localparam int SEEN_W = $clog2(MAX_NEURONS + 1);

   logic [SEEN_W-1:0]       seen_ff, seen_in;
   logic [SEEN_W+TAG_W-1:0] seen_ext;
   logic                    keep;

   assign req_ready = !queue_full;
   assign push      = req_valid && req_ready;
   assign keep      = seen_ff < SEEN_W'(MAX_NEURONS);
   assign seen_ext  = {{TAG_W{1'b0}}, seen_ff};

   // Tag the beat with its index in the run
   always_comb begin
      push_data.activation = req_data.activation;
      push_data.index      = seen_ext[TAG_W-1:0];
      push_data.last_item  = req_data.last_item;
      push_data.keep       = keep;
   end

   // Advance the item count, restart it after the last beat
   always_comb begin
      seen_in = seen_ff;
      if (push) begin
         if (req_data.last_item) begin
            seen_in = '0;
         end else if (keep) begin
            seen_in = seen_ff + SEEN_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= '0;
      end else begin
         seen_ff <= seen_in;
      end
   end
endmodule

>>> design/kwta_queue.sv
// Two-entry queue between the front and the back.
module kwta_queue import kwta_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  tag_beat_type push_data,
   output logic         full,
   input  logic         pop,
   output logic         not_empty,
   output tag_beat_type pop_data
);
   tag_beat_type mem_ff [2];
   logic         wr_ptr_ff, wr_ptr_in;
   logic         rd_ptr_ff, rd_ptr_in;
   logic [1:0]   count_ff, count_in;

   assign full      = count_ff == 2'd2;
   assign not_empty = count_ff != 2'd0;
   assign pop_data  = mem_ff[rd_ptr_ff];

   // Move pointers and count
   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the beat
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end
endmodule

>>> design/kwta_back.sv
// Back end: ranked insertion cell row, index sort and winner emission.
module kwta_back import kwta_pkg::*; #(
   parameter int MAX_WINNERS = 64
) (
   input  logic           clock,
   input  logic           reset,
   input  logic [K_W-1:0] winner_count,
   input  logic           not_empty,
   input  tag_beat_type   pop_data,
   output logic           pop,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   output rsp_beat_type   rsp_data
);
   localparam int PASS_W = $clog2(MAX_WINNERS + 1);

   back_state_type state_ff, state_in;
   logic [ACT_W-1:0]   val_ff [MAX_WINNERS];
   logic [ACT_W-1:0]   val_in [MAX_WINNERS];
   logic [TAG_W-1:0]   idx_ff [MAX_WINNERS];
   logic [TAG_W-1:0]   idx_in [MAX_WINNERS];
   logic [MAX_WINNERS-1:0] vld_ff, vld_in;
   logic [MAX_WINNERS:0]   vld_ext;
   logic [PASS_W-1:0]  pass_ff, pass_in;
   logic [K_W-1:0]     k_eff;
   logic [MAX_WINNERS:0] gt_prev;
   logic [MAX_WINNERS-1:0] gt, in_k;
   logic               do_insert, do_trim, do_sort, do_shift, sort_done;
   logic [TAG_W+OUT_IDX_W-1:0] idx_ext;

   // Clamp k to 1..MAX_WINNERS
   always_comb begin
      k_eff = winner_count;
      if (winner_count == '0) begin
         k_eff = K_W'(1);
      end else if (winner_count > K_W'(MAX_WINNERS)) begin
         k_eff = K_W'(MAX_WINNERS);
      end
   end

   assign sort_done = pass_ff == PASS_W'(MAX_WINNERS - 1);
   assign vld_ext   = {1'b0, vld_ff};

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BACK_INSERT: if (not_empty && pop_data.last_item) state_in = BACK_SORT;
         BACK_SORT:   if (sort_done) state_in = BACK_EMIT;
         BACK_EMIT:   if (!vld_ff[0]) state_in = BACK_INSERT;
         default:     state_in = BACK_INSERT;
      endcase
   end

   // State outputs
   always_comb begin
      pop       = 1'b0;
      do_sort   = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         BACK_INSERT: pop = not_empty;
         BACK_SORT:   do_sort = 1'b1;
         BACK_EMIT:   rsp_valid = vld_ff[0];
         default:     pop = 1'b0;
      endcase
   end

   assign do_insert = pop && pop_data.keep;
   // A dropped last beat still limits the emitted list to k
   assign do_trim   = pop && !pop_data.keep && pop_data.last_item;
   assign do_shift  = rsp_valid && rsp_ready;

   // Present the head cell
   always_comb begin
      idx_ext               = {{OUT_IDX_W{1'b0}}, idx_ff[0]};
      rsp_data.winner_index = idx_ext[OUT_IDX_W-1:0];
      rsp_data.last_winner  = !vld_ext[1];
   end

   // Per-cell rank compare against the incoming beat
   always_comb begin
      gt_prev[0] = 1'b1;
      for (int i = 0; i < MAX_WINNERS; i++) begin
         in_k[i]      = K_W'(i) < k_eff;
         gt[i]        = vld_ff[i] && in_k[i] && (val_ff[i] > pop_data.activation);
         gt_prev[i+1] = gt[i];
      end
   end

   // Cell row update: insert, trim, sort pass by index, or shift out
   always_comb begin
      val_in = val_ff;
      idx_in = idx_ff;
      vld_in = vld_ff;
      if (do_insert) begin
         for (int i = 0; i < MAX_WINNERS; i++) begin
            if (gt[i]) begin
               vld_in[i] = 1'b1;
            end else if (in_k[i] && gt_prev[i]) begin
               val_in[i] = pop_data.activation;
               idx_in[i] = pop_data.index;
               vld_in[i] = 1'b1;
            end else if (in_k[i] && i > 0) begin
               val_in[i] = val_ff[(i > 0) ? i - 1 : 0];
               idx_in[i] = idx_ff[(i > 0) ? i - 1 : 0];
               vld_in[i] = vld_ff[(i > 0) ? i - 1 : 0];
            end else begin
               vld_in[i] = 1'b0;
            end
         end
      end else if (do_trim) begin
         for (int i = 0; i < MAX_WINNERS; i++) begin
            vld_in[i] = vld_ff[i] && in_k[i];
         end
      end else if (do_sort) begin
         for (int i = 0; i + 1 < MAX_WINNERS; i++) begin
            if ((1'(i % 2) == pass_ff[0]) && vld_ff[i] && vld_ff[i+1] &&
                (idx_ff[i] > idx_ff[i+1])) begin
               idx_in[i]   = idx_ff[i+1];
               idx_in[i+1] = idx_ff[i];
            end
         end
      end else if (do_shift) begin
         for (int i = 0; i < MAX_WINNERS; i++) begin
            idx_in[i] = idx_ff[(i + 1 < MAX_WINNERS) ? i + 1 : i];
            vld_in[i] = vld_ext[i+1];
         end
      end
   end

   // Count sort passes
   always_comb begin
      pass_in = '0;
      if (do_sort && !sort_done) begin
         pass_in = pass_ff + PASS_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BACK_INSERT;
         vld_ff   <= '0;
         pass_ff  <= '0;
      end else begin
         state_ff <= state_in;
         vld_ff   <= vld_in;
         pass_ff  <= pass_in;
      end
   end

   always_ff @(posedge clock) begin
      val_ff <= val_in;
      idx_ff <= idx_in;
   end
endmodule

>>> design/k_winners_take_all_selector.sv
// Top level of the k-winners-take-all selector.
// Throughput: one activation beat per cycle while a run is being ranked.
// After the last beat the cell row runs an odd-even index sort, then emits one winner
// per cycle (k at most) while rsp_ready is high and returns to ranking; input queues until the queue fills.
// An accepted beat waits in the two-entry queue before it enters the cell row.
// Reset (synchronous, active high) empties the queue and cell row and sets k to 8.
module k_winners_take_all_selector import kwta_pkg::*; #(
   parameter int MAX_NEURONS = 1024,
   parameter int MAX_WINNERS = 64
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   input  req_beat_type   req_data,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   output rsp_beat_type   rsp_data,
   input  logic           csr_write_enable,
   input  logic [K_W-1:0] csr_write_data
);
   logic [K_W-1:0] k_ff, k_in;
   logic           push, pop, queue_full, not_empty;
   tag_beat_type   push_data, pop_data;

   // Hold the winner count register
   assign k_in = csr_write_enable ? csr_write_data : k_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff <= K_RESET;
      end else begin
         k_ff <= k_in;
      end
   end

   kwta_front #(.MAX_NEURONS(MAX_NEURONS)) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .push       (push),
      .push_data  (push_data),
      .queue_full (queue_full)
   );

   kwta_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (queue_full),
      .pop       (pop),
      .not_empty (not_empty),
      .pop_data  (pop_data)
   );

   kwta_back #(.MAX_WINNERS(MAX_WINNERS)) u_back (
      .clock        (clock),
      .reset        (reset),
      .winner_count (k_ff),
      .not_empty    (not_empty),
      .pop_data     (pop_data),
      .pop          (pop),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data     (rsp_data)
   );
endmodule

>>> tb/tb_k_winners_take_all_selector.sv
// Self-checking testbench for the k-winners-take-all selector.
module tb_k_winners_take_all_selector;
   import kwta_pkg::*;

   localparam int NEURON_LIMIT = 1024;
   localparam int WINNER_LIMIT = 64;
   localparam int CYCLE_LIMIT = 400000;
   localparam int SETTLE_CYCLES = 200;

   logic           clock;
   logic           reset;
   logic           req_valid;
   logic           req_ready;
   req_beat_type   req_data;
   logic           rsp_valid;
   logic           rsp_ready;
   rsp_beat_type   rsp_data;
   logic           csr_write_enable;
   logic [K_W-1:0] csr_write_data;

   // ranked list mirror of the block
   logic [ACT_W-1:0]     ranked_act[WINNER_LIMIT];
   logic [OUT_IDX_W-1:0] ranked_idx[WINNER_LIMIT];
   int                   ranked_count;
   int                   run_position;
   logic [K_W-1:0]       winner_count_reg;

   rsp_beat_type expected_winners[$];
   int           mismatch_count;
   int           cycle_count;
   bit           idle_enable;
   int           hold_cycles_left;

   k_winners_take_all_selector dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // bound the run length
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("k_winners_take_all_selector verification failed");
         $finish;
      end
   end

   task automatic report_mismatch(input string what);
      mismatch_count++;
      $display("MISMATCH at cycle %0d: %s", cycle_count, what);
   endtask

   // rank one activation and queue the winners when the run closes
   task automatic rank_activation(input logic [ACT_W-1:0] act, input logic last);
      int                   k;
      int                   pos;
      int                   top;
      logic [OUT_IDX_W-1:0] sorted_idx[$];
      rsp_beat_type         beat;
      k = (winner_count_reg == 0) ? 1 : winner_count_reg;
      if (k > WINNER_LIMIT) k = WINNER_LIMIT;
      if (run_position < NEURON_LIMIT) begin
         if (ranked_count > k) ranked_count = k;
         pos = 0;
         while (pos < ranked_count && ranked_act[pos] > act) pos++;
         if (pos < k) begin
            top = (ranked_count < k) ? ranked_count : k - 1;
            for (int i = top; i > pos; i--) begin
               ranked_act[i] = ranked_act[i-1];
               ranked_idx[i] = ranked_idx[i-1];
            end
            ranked_act[pos] = act;
            ranked_idx[pos] = run_position[OUT_IDX_W-1:0];
            if (ranked_count < k) ranked_count++;
         end
         run_position++;
      end
      if (last) begin
         top = (ranked_count < k) ? ranked_count : k;
         for (int i = 0; i < top; i++) sorted_idx = {sorted_idx, ranked_idx[i]};
         sorted_idx.sort();
         foreach (sorted_idx[i]) begin
            beat.winner_index = sorted_idx[i];
            beat.last_winner = (i == top - 1);
            expected_winners = {expected_winners, beat};
         end
         ranked_count = 0;
         run_position = 0;
      end
   endtask

   // offer one beat, with random idle gaps in front of it
   task automatic send_activation(input logic [ACT_W-1:0] act, input logic last);
      @(negedge clock);
      while (idle_enable && $urandom_range(99) < 10) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data.activation <= act;
      req_data.last_item <= last;
      do @(posedge clock); while (!(req_valid && req_ready));
      rank_activation(act, last);
   endtask

   task automatic stop_sending();
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   task automatic wait_drained();
      stop_sending();
      while (expected_winners.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_winner_count(input logic [K_W-1:0] value);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      winner_count_reg = value;
   endtask

   function automatic logic [ACT_W-1:0] random_activation();
      case ($urandom_range(3))
         0: return $urandom_range(7);
         1: return {$urandom_range(1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
         default: return $urandom;
      endcase
   endfunction

   task automatic send_run(input int length, input bit narrow);
      for (int i = 0; i < length; i++)
         send_activation(narrow ? ACT_W'($urandom_range(3)) : random_activation(),
                         i == length - 1);
   endtask

   // check each winner against the oldest expectation
   always @(posedge clock) begin
      rsp_beat_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_winners.size() == 0) begin
            report_mismatch($sformatf("unexpected winner %0d", rsp_data.winner_index));
         end else begin
            want = expected_winners.pop_front();
            if (rsp_data.winner_index !== want.winner_index)
               report_mismatch($sformatf("winner_index %0d, want %0d",
                                         rsp_data.winner_index, want.winner_index));
            if (rsp_data.last_winner !== want.last_winner)
               report_mismatch($sformatf("last_winner %0b, want %0b",
                                         rsp_data.last_winner, want.last_winner));
         end
      end
   end

   // receiver: random stalls, or a counted long hold
   always @(negedge clock) begin
      if (hold_cycles_left > 0) begin
         hold_cycles_left <= hold_cycles_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= !(idle_enable && $urandom_range(99) < 10);
      end
   end

   task automatic test_extremes();
      write_winner_count(7'd1);
      send_activation(32'h0000_0000, 1'b1);
      send_activation(32'hFFFF_FFFF, 1'b0);
      send_activation(32'h0000_0000, 1'b1);
      wait_drained();
      write_winner_count(7'd3);
      // ties: earlier index wins
      send_activation(32'h0001_0000, 1'b0);
      send_activation(32'h0001_0000, 1'b0);
      send_activation(32'h0001_0000, 1'b0);
      send_activation(32'h0001_0000, 1'b0);
      send_activation(32'h0000_8000, 1'b1);
      // short run
      send_activation(32'h8000_0000, 1'b0);
      send_activation(32'h7FFF_FFFF, 1'b1);
      wait_drained();
   endtask

   task automatic test_zero_count();
      write_winner_count(7'd0);
      send_run(6, 1'b0);
      wait_drained();
   endtask

   task automatic test_saturated_count();
      write_winner_count(7'd127);
      send_run(70, 1'b0);
      wait_drained();
      write_winner_count(7'd64);
      send_run(66, 1'b1);
      wait_drained();
   endtask

   task automatic test_count_lowered_mid_run();
      write_winner_count(7'd10);
      for (int i = 0; i < 15; i++) send_activation(random_activation(), 1'b0);
      wait_drained();
      write_winner_count(7'd3);
      send_run(5, 1'b0);
      wait_drained();
   endtask

   task automatic test_overlong_run();
      write_winner_count(7'd5);
      idle_enable = 1'b0;
      for (int i = 0; i < NEURON_LIMIT + 6; i++)
         send_activation(random_activation(), i == NEURON_LIMIT + 5);
      idle_enable = 1'b1;
      wait_drained();
   endtask

   task automatic test_backpressure();
      write_winner_count(7'd8);
      hold_cycles_left = 400;
      send_run(12, 1'b0);
      send_run(40, 1'b0);
      send_run(20, 1'b1);
      wait_drained();
   endtask

   task automatic test_random_runs();
      int sent;
      int length;
      sent = 0;
      while (sent < 400) begin
         if ($urandom_range(3) == 0) begin
            wait_drained();
            write_winner_count($urandom_range(4) == 0 ? 7'($urandom) : 7'($urandom_range(1, 16)));
         end
         length = ($urandom_range(9) == 0) ? $urandom_range(60, 150) : $urandom_range(1, 30);
         idle_enable = (sent < 100 || sent > 160);
         send_run(length, $urandom_range(3) == 0);
         sent += length;
      end
      idle_enable = 1'b1;
      wait_drained();
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_ready = 1'b0;
      csr_write_enable = 1'b0;
      csr_write_data = '0;
      hold_cycles_left = 0;
      idle_enable = 1'b1;
      mismatch_count = 0;
      cycle_count = 0;
      ranked_count = 0;
      run_position = 0;
      winner_count_reg = K_RESET;
      repeat (10) @(negedge clock);
      reset = 1'b0;
      // reset value of k
      send_run(12, 1'b0);
      wait_drained();
      test_extremes();
      test_zero_count();
      test_saturated_count();
      test_count_lowered_mid_run();
      test_overlong_run();
      test_backpressure();
      test_random_runs();
      if (mismatch_count == 0 && expected_winners.size() == 0) begin
         $display("k_winners_take_all_selector verification clean");
      end else begin
         $display("k_winners_take_all_selector verification failed");
      end
      $finish;
   end

endmodule

>>> k_winners_take_all_selector.f
design/kwta_pkg.sv
design/kwta_front.sv
design/kwta_queue.sv
design/kwta_back.sv
design/k_winners_take_all_selector.sv
tb/tb_k_winners_take_all_selector.sv
